// File: hdl/sha256bs_pkg.sv
// Shared types and constants of the SHA-256 byte stream hasher.
// Holds the controller state type, the compression control bundle, the round tables and the sigma functions.
// Depends on nothing.
`timescale 1ns / 1ps

package sha256bs_pkg;

   localparam int unsigned BUF_DEPTH   = 16;
   localparam int unsigned CHAIN_DEPTH = 8;

   localparam logic CMD_ABSORB = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_RETIRE,
      ST_EMIT_RD,
      ST_EMIT_CAP,
      ST_EMIT_HOLD
   } state_type;

   typedef struct packed {
      logic       load;
      logic       round;
      logic       retire;
      logic       w_push;
      logic       w_from_mem;
      logic [5:0] rnd;
   } core_ctrl_type;

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INITIAL_CHAIN [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

// File: hdl/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream: one absorb byte per cycle while idle (req_stall is high otherwise),
// digest as eight words on finish. The byte that fills a block loads the chain memory into
// the working words, runs the 64 rounds and adds the result back into the chain memory.
// A finish pads the rest of the block and compresses it, with a further padded block when
// the length spills into an extra block, then reads, captures and shows each digest word.
// Synchronous reset marks the chain memory as holding the initial values; no clearing pass.
`timescale 1ns / 1ps

module sha256_byte_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_word_last
);
   import sha256bs_pkg::*;

   // Controller registers.
   state_type   state_ff, state_in;
   logic [3:0]  cnt_ff;
   logic [5:0]  rnd_ff;
   logic [3:0]  pad_ptr_ff;
   logic [3:0]  pad_idx_ff;
   logic [5:0]  fill_ff;
   logic [63:0] len_ff;
   logic        finish_ff;
   logic        extra_ff;
   logic        first_pass_ff;
   logic        fresh_ff;
   logic [2:0]  emit_idx_ff;
   logic [2:0]  chain_sel_ff;

   // Payload registers.
   logic [23:0] acc_ff;
   logic [31:0] pad_word_ff;
   logic [31:0] word_ff;

   // Memory ports.
   logic        buf_we;
   logic [3:0]  buf_waddr;
   logic [31:0] buf_wdata;
   logic [3:0]  buf_raddr;
   logic [31:0] buf_q;
   logic        chain_we;
   logic [2:0]  chain_waddr;
   logic [31:0] chain_wdata;
   logic [2:0]  chain_raddr;
   logic [31:0] chain_rdata;
   logic [31:0] chain_q;

   core_ctrl_type ctrl;
   logic [31:0]   sum_word;

   logic        accept;

   // Builds the word that carries the pad byte: the bytes already gathered in the
   // assembly register, then the pad byte, then zeros.
   function automatic logic [31:0] make_pad_word(input logic [23:0] acc,
                                                 input logic [1:0]  pos);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         if (j < int'(pos)) begin
            w[31-8*j -: 8] = acc[23-8*j -: 8];
         end else if (j == int'(pos)) begin
            w[31-8*j -: 8] = PAD_BYTE;
         end
      end
      return w;
   endfunction

   assign accept    = req_valid && !req_stall;

   // While a message has not yet finished its first block, the chain memory has not been
   // written for it, so its reads are replaced by the initial hash values.
   assign chain_q = fresh_ff ? INITIAL_CHAIN[chain_sel_ff] : chain_rdata;

   sha256bs_ram #(
      .WIDTH (32),
      .DEPTH (BUF_DEPTH)
   ) u_buf_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_q)
   );

   sha256bs_ram #(
      .WIDTH (32),
      .DEPTH (CHAIN_DEPTH)
   ) u_chain_ram (
      .clock   (clock),
      .wr_en   (chain_we),
      .wr_addr (chain_waddr),
      .wr_data (chain_wdata),
      .rd_addr (chain_raddr),
      .rd_data (chain_rdata)
   );

   sha256bs_core u_core (
      .clock    (clock),
      .ctrl     (ctrl),
      .chain_q  (chain_q),
      .buf_q    (buf_q),
      .sum_word (sum_word)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_FINISH) begin
                  state_in = ST_PAD;
               end else if (fill_ff == 6'd63) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_PAD: begin
            if (pad_ptr_ff == 4'd15) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff == 4'd8) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (rnd_ff == 6'd63) begin
               state_in = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            if (cnt_ff == 4'd8) begin
               priority if (!finish_ff) begin
                  state_in = ST_IDLE;
               end else if (extra_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_RD:  state_in = ST_EMIT_CAP;
         ST_EMIT_CAP: state_in = ST_EMIT_HOLD;
         ST_EMIT_HOLD: begin
            if (!rsp_stall) begin
               state_in = (emit_idx_ff == 3'd7) ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and memory controls.
   always_comb begin
      req_stall        = 1'b1;
      rsp_valid        = 1'b0;
      buf_we           = 1'b0;
      buf_waddr        = pad_ptr_ff;
      buf_wdata        = '0;
      buf_raddr        = '0;
      chain_we         = 1'b0;
      chain_waddr      = cnt_ff[2:0] - 3'd1;
      chain_wdata      = sum_word;
      chain_raddr      = emit_idx_ff;
      ctrl             = '0;
      ctrl.rnd         = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // No byte is taken while reset is held.
            req_stall = reset;
            buf_waddr = fill_ff[5:2];
            buf_wdata = {acc_ff, req_data_byte};
            buf_we    = accept && (req_cmd == CMD_ABSORB) && (fill_ff[1:0] == 2'd3);
         end
         ST_PAD: begin
            buf_we = 1'b1;
            priority if (first_pass_ff && (pad_ptr_ff == pad_idx_ff)) begin
               buf_wdata = pad_word_ff;
            end else if (!extra_ff && (pad_ptr_ff == 4'd14)) begin
               buf_wdata = len_ff[63:32];
            end else if (!extra_ff && (pad_ptr_ff == 4'd15)) begin
               buf_wdata = len_ff[31:0];
            end else begin
               buf_wdata = '0;
            end
         end
         ST_LOAD: begin
            // The schedule window needs word 0 as the rounds start, so the buffer
            // reads run ahead of the rounds.
            chain_raddr     = cnt_ff[2:0];
            ctrl.load       = (cnt_ff != 4'd0);
            buf_raddr       = (cnt_ff == 4'd8) ? 4'd1 : 4'd0;
            ctrl.w_push     = (cnt_ff == 4'd8);
            ctrl.w_from_mem = 1'b1;
         end
         ST_ROUND: begin
            ctrl.round      = 1'b1;
            ctrl.w_push     = 1'b1;
            ctrl.w_from_mem = (rnd_ff < 6'd15);
            buf_raddr       = rnd_ff[3:0] + 4'd2;
         end
         ST_RETIRE: begin
            chain_raddr = cnt_ff[2:0];
            chain_we    = (cnt_ff != 4'd0);
            ctrl.retire = (cnt_ff != 4'd0);
         end
         ST_EMIT_RD: begin
         end
         ST_EMIT_CAP: begin
         end
         ST_EMIT_HOLD: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         rnd_ff        <= '0;
         pad_ptr_ff    <= '0;
         pad_idx_ff    <= '0;
         fill_ff       <= '0;
         len_ff        <= '0;
         finish_ff     <= 1'b0;
         extra_ff      <= 1'b0;
         first_pass_ff <= 1'b0;
         fresh_ff      <= 1'b1;
         emit_idx_ff   <= '0;
         chain_sel_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         chain_sel_ff <= chain_raddr;
         unique case (state_ff)
            ST_IDLE: begin
               cnt_ff <= '0;
               if (accept) begin
                  if (req_cmd == CMD_FINISH) begin
                     finish_ff     <= 1'b1;
                     extra_ff      <= (fill_ff[5:3] == 3'd7);
                     first_pass_ff <= 1'b1;
                     pad_ptr_ff    <= fill_ff[5:2];
                     pad_idx_ff    <= fill_ff[5:2];
                  end else begin
                     finish_ff <= 1'b0;
                     fill_ff   <= fill_ff + 6'd1;
                     len_ff    <= len_ff + 64'd8;
                  end
               end
            end
            ST_PAD: begin
               cnt_ff     <= '0;
               pad_ptr_ff <= pad_ptr_ff + 4'd1;
            end
            ST_LOAD: begin
               if (cnt_ff == 4'd8) begin
                  cnt_ff <= '0;
                  rnd_ff <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               cnt_ff <= '0;
            end
            ST_RETIRE: begin
               if (cnt_ff == 4'd8) begin
                  cnt_ff      <= '0;
                  fresh_ff    <= 1'b0;
                  emit_idx_ff <= '0;
                  if (finish_ff && extra_ff) begin
                     extra_ff      <= 1'b0;
                     first_pass_ff <= 1'b0;
                     pad_ptr_ff    <= '0;
                  end
               end else begin
                  cnt_ff <= cnt_ff + 4'd1;
               end
            end
            ST_EMIT_RD: begin
            end
            ST_EMIT_CAP: begin
            end
            ST_EMIT_HOLD: begin
               if (!rsp_stall) begin
                  emit_idx_ff <= emit_idx_ff + 3'd1;
                  if (emit_idx_ff == 3'd7) begin
                     // Digest delivered: the next message starts from scratch.
                     fresh_ff  <= 1'b1;
                     fill_ff   <= '0;
                     len_ff    <= '0;
                     finish_ff <= 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         if (req_cmd == CMD_FINISH) begin
            pad_word_ff <= make_pad_word(acc_ff, fill_ff[1:0]);
         end else begin
            unique case (fill_ff[1:0])
               2'd0: acc_ff[23:16] <= req_data_byte;
               2'd1: acc_ff[15:8]  <= req_data_byte;
               2'd2: acc_ff[7:0]   <= req_data_byte;
               2'd3: begin
               end
            endcase
         end
      end
      if (state_ff == ST_EMIT_CAP) begin
         word_ff <= chain_q;
      end
   end

   assign rsp_digest_word = word_ff;
   assign rsp_word_index  = emit_idx_ff;
   assign rsp_word_last   = (emit_idx_ff == 3'd7);

   // A finish word always starts the padding sweep.
   a_finish_pads: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_FINISH) |=> (state_ff == ST_PAD))
      else $error("finish word did not start padding");

   // The byte that completes a block starts a compression with an empty buffer count.
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_ABSORB && fill_ff == 6'd63)
      |=> (state_ff == ST_LOAD && fill_ff == 6'd0))
      else $error("full block did not start compression");

   // The rounds always begin at round zero.
   a_round_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD && cnt_ff == 4'd8) |=> (state_ff == ST_ROUND && rnd_ff == 6'd0))
      else $error("rounds did not start at zero");

   // Once the last digest word is taken, the message state is back at its start.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_word_last)
      |=> (fresh_ff && fill_ff == 6'd0 && len_ff == 64'd0 && state_ff == ST_IDLE))
      else $error("message state not restarted after digest");

endmodule

// File: hdl/sha256bs_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sha256bs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sha256bs_core.sv
// Compression datapath: the eight working words and the sixteen-word message schedule window.
// Depends on sha256bs_pkg for the round constants, sigma functions and control bundle.
`timescale 1ns / 1ps

module sha256bs_core (
   input  logic                        clock,
   input  sha256bs_pkg::core_ctrl_type ctrl,
   input  logic [31:0]                 chain_q,
   input  logic [31:0]                 buf_q,
   output logic [31:0]                 sum_word
);
   import sha256bs_pkg::*;

   logic [31:0] wk_ff [0:7];
   logic [31:0] ws_ff [0:15];

   logic [31:0] t1;
   logic [31:0] t2;
   logic [31:0] w_new;

   always_comb begin
      t1 = wk_ff[7] + big_sigma1(wk_ff[4])
         + ((wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]))
         + ROUND_K[ctrl.rnd] + ws_ff[15];
      t2 = big_sigma0(wk_ff[0])
         + ((wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]));
      w_new = ws_ff[0] + small_sigma0(ws_ff[1]) + ws_ff[9] + small_sigma1(ws_ff[14]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load || ctrl.retire) begin
         // Words stream in through position 7 and out through position 0, one per cycle.
         for (int i = 0; i < 7; i++) begin
            wk_ff[i] <= wk_ff[i+1];
         end
         wk_ff[7] <= ctrl.load ? chain_q : wk_ff[0];
      end else if (ctrl.round) begin
         wk_ff[7] <= wk_ff[6];
         wk_ff[6] <= wk_ff[5];
         wk_ff[5] <= wk_ff[4];
         wk_ff[4] <= wk_ff[3] + t1;
         wk_ff[3] <= wk_ff[2];
         wk_ff[2] <= wk_ff[1];
         wk_ff[1] <= wk_ff[0];
         wk_ff[0] <= t1 + t2;
      end
      if (ctrl.w_push) begin
         for (int i = 0; i < 15; i++) begin
            ws_ff[i] <= ws_ff[i+1];
         end
         ws_ff[15] <= ctrl.w_from_mem ? buf_q : w_new;
      end
   end

   assign sum_word = chain_q + wk_ff[0];

endmodule
